FILE: hdl/ipatv_pkg.sv
// ipatv_pkg: shared types, constants and character classes for the
// address text validator. No dependencies.
`timescale 1ns / 1ps

package ipatv_pkg;

  localparam int unsigned CharWidth = 8;

  // Result form codes
  localparam logic [1:0] FORM_V6   = 2'd0;
  localparam logic [1:0] FORM_V4   = 2'd1;
  localparam logic [1:0] FORM_NONE = 2'd2;

  localparam logic [9:0] V4_MAX_GROUP_VALUE = 10'd255;
  localparam logic [1:0] V4_MAX_DIGITS      = 2'd3;
  localparam logic [2:0] V4_DOTS_NEEDED     = 3'd3;
  localparam logic [2:0] V4_DOTS_SAT        = 3'd4;
  localparam logic [2:0] V6_MAX_GROUP_CHARS = 3'd4;
  localparam logic [3:0] V6_COLON_LIMIT     = 4'd8;

  localparam logic [CharWidth-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CharWidth-1:0] CHAR_DOT   = 8'h2E;

  typedef struct packed {
    logic       is_valid;
    logic [1:0] form_seen;
  } verdict_t;

  function automatic logic is_dec(input logic [CharWidth-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [CharWidth-1:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

FILE: hdl/ipatv_if.sv
// ipatv_if: valid/ready channel interfaces for character beats and verdict beats.
// Depends on ipatv_pkg for the character width.
`timescale 1ns / 1ps

interface ipatv_char_if;
  logic                            valid;
  logic                            ready;
  logic [ipatv_pkg::CharWidth-1:0] char_byte;
  logic                            last_char;

  modport source(output valid, output char_byte, output last_char, input ready);
  modport sink(input valid, input char_byte, input last_char, output ready);
endinterface

interface ipatv_verdict_if;
  logic       valid;
  logic       ready;
  logic       is_valid;
  logic [1:0] form_seen;

  modport source(output valid, output is_valid, output form_seen, input ready);
  modport sink(input valid, input is_valid, input form_seen, output ready);
endinterface

FILE: hdl/ipatv_tracker.sv
// ipatv_tracker: per-string IPv4/IPv6 rule state, updated once per accepted
// character beat; gives the verdict for the string ending at this beat.
// Depends on ipatv_pkg.
`timescale 1ns / 1ps

module ipatv_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [ipatv_pkg::CharWidth-1:0] char_byte,
  input  logic                            last_char,
  output ipatv_pkg::verdict_t             verdict
);

  logic       saw_colon, saw_colon_next;
  logic       saw_dot, saw_dot_next;
  logic       v4_failed, v4_failed_next;
  logic [1:0] v4_group_digits, v4_group_digits_next;
  logic [9:0] v4_group_value, v4_group_value_next;
  logic [2:0] v4_dots, v4_dots_next;
  logic       v6_failed, v6_failed_next;
  logic [2:0] v6_group_chars, v6_group_chars_next;
  logic [3:0] v6_colons, v6_colons_next;
  logic       v6_compressed, v6_compressed_next;

  logic is_colon, is_dot;

  assign is_colon = (char_byte == ipatv_pkg::CHAR_COLON);
  assign is_dot   = (char_byte == ipatv_pkg::CHAR_DOT);

  always_comb begin
    saw_colon_next       = saw_colon | is_colon;
    saw_dot_next         = saw_dot | is_dot;
    v4_failed_next       = v4_failed;
    v4_group_digits_next = v4_group_digits;
    v4_group_value_next  = v4_group_value;
    v4_dots_next         = v4_dots;
    v6_failed_next       = v6_failed;
    v6_group_chars_next  = v6_group_chars;
    v6_colons_next       = v6_colons;
    v6_compressed_next   = v6_compressed;

    // IPv4 track
    if (is_dot) begin
      if (v4_group_digits == 2'd0 || v4_group_value > ipatv_pkg::V4_MAX_GROUP_VALUE) begin
        v4_failed_next = 1'b1;
      end
      v4_group_digits_next = 2'd0;
      v4_group_value_next  = 10'd0;
      if (v4_dots < ipatv_pkg::V4_DOTS_SAT) begin
        v4_dots_next = v4_dots + 3'd1;
      end
    end else if (!ipatv_pkg::is_dec(char_byte)) begin
      v4_failed_next = 1'b1;
    end else if (v4_group_digits >= ipatv_pkg::V4_MAX_DIGITS) begin
      v4_failed_next = 1'b1;
    end else begin
      // group value is at most 99 here, so x10 plus a digit fits 10 bits
      v4_group_value_next  = 10'(v4_group_value * 10'd10) + {6'd0, char_byte[3:0]};
      v4_group_digits_next = v4_group_digits + 2'd1;
    end

    // IPv6 track; a colon closing an empty group marks compression
    if (is_colon) begin
      if (v6_group_chars == 3'd0) begin
        if (v6_compressed) begin
          v6_failed_next = 1'b1;
        end
        v6_compressed_next = 1'b1;
      end
      v6_group_chars_next = 3'd0;
      if (v6_colons < ipatv_pkg::V6_COLON_LIMIT) begin
        v6_colons_next = v6_colons + 4'd1;
      end
    end else if (!ipatv_pkg::is_hex(char_byte)) begin
      v6_failed_next = 1'b1;
    end else if (v6_group_chars >= ipatv_pkg::V6_MAX_GROUP_CHARS) begin
      v6_failed_next = 1'b1;
    end else begin
      v6_group_chars_next = v6_group_chars + 3'd1;
    end
  end

  always_comb begin
    if (saw_colon_next) begin
      verdict.form_seen = ipatv_pkg::FORM_V6;
      verdict.is_valid  = !v6_failed_next &&
                          !(v6_group_chars_next == 3'd0 && v6_compressed_next) &&
                          (v6_colons_next < ipatv_pkg::V6_COLON_LIMIT);
    end else if (saw_dot_next) begin
      verdict.form_seen = ipatv_pkg::FORM_V4;
      verdict.is_valid  = !v4_failed_next &&
                          (v4_dots_next == ipatv_pkg::V4_DOTS_NEEDED) &&
                          (v4_group_digits_next != 2'd0) &&
                          (v4_group_value_next <= ipatv_pkg::V4_MAX_GROUP_VALUE);
    end else begin
      verdict.form_seen = ipatv_pkg::FORM_NONE;
      verdict.is_valid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      saw_colon       <= 1'b0;
      saw_dot         <= 1'b0;
      v4_failed       <= 1'b0;
      v4_group_digits <= 2'd0;
      v4_group_value  <= 10'd0;
      v4_dots         <= 3'd0;
      v6_failed       <= 1'b0;
      v6_group_chars  <= 3'd0;
      v6_colons       <= 4'd0;
      v6_compressed   <= 1'b0;
    end else if (step) begin
      saw_colon       <= saw_colon_next;
      saw_dot         <= saw_dot_next;
      v4_failed       <= v4_failed_next;
      v4_group_digits <= v4_group_digits_next;
      v4_group_value  <= v4_group_value_next;
      v4_dots         <= v4_dots_next;
      v6_failed       <= v6_failed_next;
      v6_group_chars  <= v6_group_chars_next;
      v6_colons       <= v6_colons_next;
      v6_compressed   <= v6_compressed_next;
    end
  end

endmodule

FILE: hdl/ipatv_out_reg.sv
// ipatv_out_reg: result register driving the verdict channel.
// Depends on ipatv_pkg and ipatv_if.
`timescale 1ns / 1ps

module ipatv_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  ipatv_pkg::verdict_t     verdict,
  output logic                    can_load,
  ipatv_verdict_if.source         verdicts
);

  logic                res_valid;
  ipatv_pkg::verdict_t res_data;

  // Slot is free when empty or being drained this cycle
  assign can_load = !res_valid || verdicts.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (verdicts.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= verdict;
    end
  end

  assign verdicts.valid     = res_valid;
  assign verdicts.is_valid  = res_data.is_valid;
  assign verdicts.form_seen = res_data.form_seen;

endmodule

FILE: hdl/ip_address_text_validator_top.sv
// Address text validator: takes one character beat per clock on the chars
// channel and, in the cycle after the beat flagged last_char, presents a single
// verdict beat (is_valid, form_seen) on the verdicts channel. Any colon picks
// IPv6 rules, otherwise any dot picks IPv4 rules, otherwise the string is
// rejected. Throughput is one character per cycle; the only stall comes from
// the one-entry result register: chars.ready drops while a verdict waits and
// verdicts.ready is low. Rule state clears after each last character.
// Depends on ipatv_pkg, ipatv_if, ipatv_tracker and ipatv_out_reg.
`timescale 1ns / 1ps

module ip_address_text_validator_top (
  input  logic            clk,
  input  logic            rst,
  ipatv_char_if.sink      chars,
  ipatv_verdict_if.source verdicts
);

  logic                step;
  logic                can_load;
  ipatv_pkg::verdict_t verdict;

  assign chars.ready = can_load;
  assign step        = chars.valid && can_load;

  ipatv_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_byte (chars.char_byte),
    .last_char (chars.last_char),
    .verdict   (verdict)
  );

  ipatv_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step && chars.last_char),
    .verdict  (verdict),
    .can_load (can_load),
    .verdicts (verdicts)
  );

`ifndef SYNTHESIS
  // A verdict beat appears only right after a last character beat
  a_rose_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(verdicts.valid) |-> $past(chars.valid && chars.ready && chars.last_char))
    else $error("verdict appeared without a last character");

  // Every accepted last character yields a pending verdict
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && chars.last_char) |=> verdicts.valid)
    else $error("last character produced no verdict");

  // A string with neither colon nor dot is never valid
  a_none_invalid: assert property (@(posedge clk) disable iff (rst)
    (verdicts.valid && verdicts.form_seen == ipatv_pkg::FORM_NONE) |-> !verdicts.is_valid)
    else $error("formless string reported valid");

  // No character taken while a stalled verdict occupies the register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (verdicts.valid && !verdicts.ready) |-> !chars.ready)
    else $error("input accepted over a stalled verdict");
`endif

endmodule
